// ----- src/quaternion_to_rotation_matrix_macros.svh -----
// Assertion macros for the quaternion to rotation matrix block.
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define Q2RM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define Q2RM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/q2rm_pkg.sv -----
// Constants shared by the quaternion to rotation matrix block.
package q2rm_pkg;

  localparam int COMP_WIDTH_DEF = 16;
  // Quotient bits of 2^16*num/den before the final rounding halving.
  localparam int QUOT_BITS      = 17;
  localparam int ENT_W          = 16;
  localparam int N_ENT          = 9;
  localparam int ONE_Q14        = 16384;

  // Matrix entries in row-major order.
  localparam int E00 = 0;
  localparam int E01 = 1;
  localparam int E02 = 2;
  localparam int E10 = 3;
  localparam int E11 = 4;
  localparam int E12 = 5;
  localparam int E20 = 6;
  localparam int E21 = 7;
  localparam int E22 = 8;

endpackage

// ----- src/quaternion_to_rotation_matrix.sv -----
// Pipelined quaternion to 3x3 rotation matrix converter, top level.
//
//   channel  direction  handshake                 payload
//   in_      input      in_valid / in_stall       quat_x, quat_y, quat_z, quat_w, kind
//   out_     output     out_valid / out_stall     row0_col0 .. row2_col2, zero_norm
//
// One item enters per cycle while out_stall does not hold the pipeline; stages:
// one product stage, one sum stage, one restoring division step per quotient bit
// (nine lanes in parallel) and one rounding and output stage.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
// Each stage holds while it is valid and the stage after it holds; bubbles
// collapse, and in_stall rises only when every stage carries an item.

`include "quaternion_to_rotation_matrix_macros.svh"

module quaternion_to_rotation_matrix #(
  parameter int COMP_WIDTH = q2rm_pkg::COMP_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [COMP_WIDTH-1:0]              in_quat_x,
  input  logic [COMP_WIDTH-1:0]              in_quat_y,
  input  logic [COMP_WIDTH-1:0]              in_quat_z,
  input  logic [COMP_WIDTH-1:0]              in_quat_w,
  input  logic                               in_kind,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [q2rm_pkg::ENT_W-1:0]  out_row0_col0,
  output logic signed [q2rm_pkg::ENT_W-1:0]  out_row0_col1,
  output logic signed [q2rm_pkg::ENT_W-1:0]  out_row0_col2,
  output logic signed [q2rm_pkg::ENT_W-1:0]  out_row1_col0,
  output logic signed [q2rm_pkg::ENT_W-1:0]  out_row1_col1,
  output logic signed [q2rm_pkg::ENT_W-1:0]  out_row1_col2,
  output logic signed [q2rm_pkg::ENT_W-1:0]  out_row2_col0,
  output logic signed [q2rm_pkg::ENT_W-1:0]  out_row2_col1,
  output logic signed [q2rm_pkg::ENT_W-1:0]  out_row2_col2,
  output logic                               out_zero_norm
);

  localparam int W   = COMP_WIDTH;
  localparam int PW  = 2 * W;       // product width
  localparam int NW  = 2 * W + 1;   // norm, numerator and remainder width
  localparam int QB  = q2rm_pkg::QUOT_BITS;
  localparam int NE  = q2rm_pkg::N_ENT;
  localparam int EW  = q2rm_pkg::ENT_W;
  localparam int VW  = QB + 2;      // signed entry before the clamp

  localparam int ST_PROD = 0;
  localparam int ST_SUM  = 1;
  localparam int ST_DIV0 = 2;
  localparam int ST_OUT  = ST_DIV0 + QB;
  localparam int NST     = ST_OUT + 1;

  localparam logic signed [VW-1:0] ONE_V = VW'(q2rm_pkg::ONE_Q14);

  // ---------------------------------------------------------------------------
  // Stage control: a stage loads when it is empty or the next one advances.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld_r;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[ST_OUT];

  // ---------------------------------------------------------------------------
  // Product stage: four squares and six cross products, one multiplier each.
  // ---------------------------------------------------------------------------
  logic signed [W-1:0]  qx, qy, qz, qw;
  logic signed [PW-1:0] xx_r, yy_r, zz_r, ww_r;
  logic signed [PW-1:0] xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic                 kind0_r;

  assign qx = $signed(in_quat_x);
  assign qy = $signed(in_quat_y);
  assign qz = $signed(in_quat_z);
  assign qw = $signed(in_quat_w);

  always_ff @(posedge clk) begin
    if (rdy[ST_PROD]) begin
      xx_r    <= qx * qx;
      yy_r    <= qy * qy;
      zz_r    <= qz * qz;
      ww_r    <= qw * qw;
      xy_r    <= qx * qy;
      xz_r    <= qx * qz;
      yz_r    <= qy * qz;
      wx_r    <= qw * qx;
      wy_r    <= qw * qy;
      wz_r    <= qw * qz;
      kind0_r <= in_kind;
    end
  end

  // ---------------------------------------------------------------------------
  // Sum stage: norm, diagonal square sums and signed off-diagonal sums.
  // ---------------------------------------------------------------------------
  function automatic logic [NW-1:0] ext(input logic signed [PW-1:0] v);
    return {v[PW-1], v};
  endfunction

  logic [NW-1:0] sum_nxt [NE];
  logic [NW-1:0] num_nxt [NE];
  logic [NE-1:0] sgn_nxt;
  logic [NW-1:0] n_nxt;

  logic [NW-1:0] num_r [NE];
  logic [NE-1:0] sgn_r;
  logic [NW-1:0] den_r;
  logic          zero_r;
  logic          kind1_r;

  always_comb begin
    n_nxt = ext(xx_r) + ext(yy_r) + ext(zz_r) + ext(ww_r);
    sum_nxt[q2rm_pkg::E00] = ext(yy_r) + ext(zz_r);
    sum_nxt[q2rm_pkg::E11] = ext(xx_r) + ext(zz_r);
    sum_nxt[q2rm_pkg::E22] = ext(xx_r) + ext(yy_r);
    sum_nxt[q2rm_pkg::E01] = ext(xy_r) - ext(wz_r);
    sum_nxt[q2rm_pkg::E02] = ext(xz_r) + ext(wy_r);
    sum_nxt[q2rm_pkg::E10] = ext(xy_r) + ext(wz_r);
    sum_nxt[q2rm_pkg::E12] = ext(yz_r) - ext(wx_r);
    sum_nxt[q2rm_pkg::E20] = ext(xz_r) - ext(wy_r);
    sum_nxt[q2rm_pkg::E21] = ext(yz_r) + ext(wx_r);
    for (int l = 0; l < NE; l++) begin
      // diagonal sums are never negative, so the same magnitude logic serves
      sgn_nxt[l] = sum_nxt[l][NW-1];
      num_nxt[l] = sgn_nxt[l] ? (~sum_nxt[l] + NW'(1)) : sum_nxt[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_SUM]) begin
      num_r   <= num_nxt;
      sgn_r   <= sgn_nxt;
      den_r   <= n_nxt;
      zero_r  <= (n_nxt == '0);
      kind1_r <= kind0_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Division: one restoring step per stage, nine lanes, shared divisor.
  // ---------------------------------------------------------------------------
  logic [NW-1:0] rem_r  [QB][NE];
  logic [QB-1:0] quo_r  [QB][NE];
  logic [NE-1:0] dsgn_r [QB];
  logic [NW-1:0] dden_r [QB];
  logic          dzero_r [QB];
  logic          dkind_r [QB];

  for (genvar g = 0; g < QB; g++) begin : g_div
    logic [NW-1:0] rem_nxt [NE];
    logic [QB-1:0] quo_nxt [NE];
    logic [NW:0]   trial   [NE];
    logic [NW:0]   diff    [NE];
    logic          ge      [NE];

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NE; l++) begin
          trial[l]   = {1'b0, num_r[l]};
          diff[l]    = trial[l] - {1'b0, den_r};
          ge[l]      = (trial[l] >= {1'b0, den_r});
          rem_nxt[l] = ge[l] ? diff[l][NW-1:0] : num_r[l];
          quo_nxt[l] = {{(QB-1){1'b0}}, ge[l]};
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[ST_DIV0]) begin
          rem_r[0]   <= rem_nxt;
          quo_r[0]   <= quo_nxt;
          dsgn_r[0]  <= sgn_r;
          dden_r[0]  <= den_r;
          dzero_r[0] <= zero_r;
          dkind_r[0] <= kind1_r;
        end
      end
    end else begin : g_step
      always_comb begin
        for (int l = 0; l < NE; l++) begin
          trial[l]   = {rem_r[g-1][l], 1'b0};
          diff[l]    = trial[l] - {1'b0, dden_r[g-1]};
          ge[l]      = (trial[l] >= {1'b0, dden_r[g-1]});
          rem_nxt[l] = ge[l] ? diff[l][NW-1:0] : trial[l][NW-1:0];
          quo_nxt[l] = {quo_r[g-1][l][QB-2:0], ge[l]};
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[ST_DIV0+g]) begin
          rem_r[g]   <= rem_nxt;
          quo_r[g]   <= quo_nxt;
          dsgn_r[g]  <= dsgn_r[g-1];
          dden_r[g]  <= dden_r[g-1];
          dzero_r[g] <= dzero_r[g-1];
          dkind_r[g] <= dkind_r[g-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: round half away, apply sign or diagonal offset, clamp,
  // substitute identity for a zero quaternion, transpose for kind 1.
  // ---------------------------------------------------------------------------
  logic [QB:0]           qinc  [NE];
  logic signed [VW-1:0]  qrnd  [NE];
  logic signed [VW-1:0]  ent   [NE];
  logic signed [VW-1:0]  clp   [NE];
  logic signed [EW-1:0]  ent_nxt [NE];
  logic signed [EW-1:0]  ent_r   [NE];
  logic                  zero_norm_r;
  logic                  is_diag;

  always_comb begin
    for (int l = 0; l < NE; l++) begin
      is_diag = (l == q2rm_pkg::E00) || (l == q2rm_pkg::E11) || (l == q2rm_pkg::E22);
      qinc[l] = {1'b0, quo_r[QB-1][l]} + (QB+1)'(1);
      qrnd[l] = $signed({2'b00, qinc[l][QB:1]});
      if (is_diag) begin
        ent[l] = ONE_V - qrnd[l];
      end else if (dsgn_r[QB-1][l]) begin
        ent[l] = -qrnd[l];
      end else begin
        ent[l] = qrnd[l];
      end
      if (ent[l] > ONE_V) begin
        clp[l] = ONE_V;
      end else if (ent[l] < -ONE_V) begin
        clp[l] = -ONE_V;
      end else begin
        clp[l] = ent[l];
      end
      if (dzero_r[QB-1]) begin
        clp[l] = is_diag ? ONE_V : '0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ent_nxt[i*3+j] = dkind_r[QB-1] ? clp[j*3+i][EW-1:0] : clp[i*3+j][EW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      ent_r       <= ent_nxt;
      zero_norm_r <= dzero_r[QB-1];
    end
  end

  assign out_row0_col0 = ent_r[q2rm_pkg::E00];
  assign out_row0_col1 = ent_r[q2rm_pkg::E01];
  assign out_row0_col2 = ent_r[q2rm_pkg::E02];
  assign out_row1_col0 = ent_r[q2rm_pkg::E10];
  assign out_row1_col1 = ent_r[q2rm_pkg::E11];
  assign out_row1_col2 = ent_r[q2rm_pkg::E12];
  assign out_row2_col0 = ent_r[q2rm_pkg::E20];
  assign out_row2_col1 = ent_r[q2rm_pkg::E21];
  assign out_row2_col2 = ent_r[q2rm_pkg::E22];
  assign out_zero_norm = zero_norm_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `Q2RM_ASSERT_NOW(a_stall_only_full, clk, rst_n, in_stall, (&vld_r), "input stalled with a free stage")
  `Q2RM_ASSERT_NEXT(a_accept_lands, clk, rst_n, (in_valid && !in_stall), vld_r[ST_PROD], "accepted transfer not captured")
  `Q2RM_ASSERT_NOW(a_zero_identity, clk, rst_n, (out_valid && out_zero_norm), ((out_row0_col0 == EW'(q2rm_pkg::ONE_Q14)) && (out_row0_col1 == '0) && (out_row2_col2 == EW'(q2rm_pkg::ONE_Q14))), "zero quaternion without identity")

endmodule
